// File: sv/c_bracket_nesting_checker_defines.svh
// Assertion macros used by the back end of the bracket nesting checker RTL.
`ifndef C_BRACKET_NESTING_CHECKER_DEFINES_SVH
`define C_BRACKET_NESTING_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBN_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cbn_pkg.sv
// Shared types and constants of the bracket nesting checker.
`default_nettype none

package cbn_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int QUEUE_DEPTH     = 2;
   localparam int DEPTH_W         = 7;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef enum logic [1:0] {
      FUNC_CHAR = 2'd0,
      FUNC_EOL  = 2'd1,
      FUNC_EOT  = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CLS_OTHER  = 3'd0,
      CLS_OPEN   = 3'd1,
      CLS_CLOSE  = 3'd2,
      CLS_QUOTE  = 3'd3,
      CLS_STAR   = 3'd4,
      CLS_SLASH  = 3'd5,
      CLS_BSLASH = 3'd6
   } cls_type;

   typedef enum logic [1:0] {
      BR_PAREN  = 2'd0,
      BR_SQUARE = 2'd1,
      BR_CURLY  = 2'd2
   } br_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MISMATCH = 3'd1,
      ST_QUOTE    = 3'd2,
      ST_UNCLOSED = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   // One classified word as it travels from front to back.
   typedef struct packed {
      func_type kind;
      cls_type  cls;
      br_type   code;
   } item_type;

endpackage

`default_nettype wire

// File: sv/cbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cbn_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/cbn_front.sv
// Front end: accepts input words and classifies each character.
`default_nettype none

module cbn_front import cbn_pkg::*; (
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] ch
   input  wire logic [1:0] req_tuser,   // [1:0] func
   input  wire logic       q_full,
   output logic            q_push,
   output item_type        q_item
);

   always_comb begin
      q_item.kind = func_type'(req_tuser);
      q_item.cls  = CLS_OTHER;
      q_item.code = BR_PAREN;
      case (req_tdata)
         CH_LPAREN: begin q_item.cls = CLS_OPEN;  q_item.code = BR_PAREN;  end
         CH_LBRACK: begin q_item.cls = CLS_OPEN;  q_item.code = BR_SQUARE; end
         CH_LBRACE: begin q_item.cls = CLS_OPEN;  q_item.code = BR_CURLY;  end
         CH_RPAREN: begin q_item.cls = CLS_CLOSE; q_item.code = BR_PAREN;  end
         CH_RBRACK: begin q_item.cls = CLS_CLOSE; q_item.code = BR_SQUARE; end
         CH_RBRACE: begin q_item.cls = CLS_CLOSE; q_item.code = BR_CURLY;  end
         CH_QUOTE:  q_item.cls = CLS_QUOTE;
         CH_STAR:   q_item.cls = CLS_STAR;
         CH_SLASH:  q_item.cls = CLS_SLASH;
         CH_BSLASH: q_item.cls = CLS_BSLASH;
         default:   q_item.cls = CLS_OTHER;
      endcase
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

`default_nettype wire

// File: sv/cbn_queue.sv
// Short FIFO of classified words between front and back.
`default_nettype none

module cbn_queue import cbn_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   output logic      full,
   input  wire logic pop,
   output logic      head_valid,
   output item_type  head_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: sv/cbn_back.sv
// Back end: comment and quote tracking, bracket stack and result register.
`default_nettype none

`include "c_bracket_nesting_checker_defines.svh"

module cbn_back import cbn_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [2:0] status, [9:3] nesting_depth, [10] in_comment
   output logic             rsp_tlast    // final_res
);

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);

   logic [SP_W-1:0]  sp_ff, sp_in;
   logic             block_ff, block_in;
   logic             line_ff, line_in;
   logic             quote_ff, quote_in;
   cls_type          prev_ff, prev_in;
   logic             consumed_ff, consumed_in;
   status_type       err_ff, err_in;
   logic             fwd_hit_ff, fwd_hit_in;
   br_type           fwd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff;
   logic             rsp_last_ff;

   logic             fire;
   logic             pair_ok;
   br_type           top;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   br_type           ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [1:0]       ram_rd_data;

   assign fire    = q_valid && (!rsp_valid_ff || rsp_tready);
   assign q_pop   = fire;
   assign pair_ok = !consumed_ff;
   // A push in the previous cycle is not yet visible on the RAM read port.
   assign top     = fwd_hit_ff ? fwd_data_ff : br_type'(ram_rd_data);

   always_comb begin
      sp_in       = sp_ff;
      block_in    = block_ff;
      line_in     = line_ff;
      quote_in    = quote_ff;
      prev_in     = prev_ff;
      consumed_in = consumed_ff;
      err_in      = err_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = sp_ff[IDX_W-1:0];
      ram_wr_data = q_item.code;
      if (fire && err_ff == ST_OK) begin
         case (q_item.kind)
            FUNC_CHAR: begin
               if (!line_ff) begin
                  if (pair_ok && block_ff && prev_ff == CLS_STAR && q_item.cls == CLS_SLASH) begin
                     block_in    = 1'b0;
                     prev_in     = q_item.cls;
                     consumed_in = 1'b1;
                  end else if (pair_ok && !block_ff && !quote_ff && prev_ff == CLS_SLASH &&
                               (q_item.cls == CLS_SLASH || q_item.cls == CLS_STAR)) begin
                     if (q_item.cls == CLS_SLASH) begin
                        line_in = 1'b1;
                     end else begin
                        block_in = 1'b1;
                     end
                     prev_in     = q_item.cls;
                     consumed_in = 1'b1;
                  end else begin
                     prev_in     = q_item.cls;
                     consumed_in = 1'b0;
                     if (!block_ff) begin
                        if (quote_ff) begin
                           if (q_item.cls == CLS_QUOTE && prev_ff != CLS_BSLASH) begin
                              quote_in = 1'b0;
                           end
                        end else begin
                           case (q_item.cls)
                              CLS_QUOTE: quote_in = 1'b1;
                              CLS_OPEN: begin
                                 if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                                    err_in = ST_OVERFLOW;
                                 end else begin
                                    ram_wr_en = 1'b1;
                                    sp_in     = sp_ff + 1'b1;
                                 end
                              end
                              CLS_CLOSE: begin
                                 if (sp_ff == '0) begin
                                    err_in = ST_MISMATCH;
                                 end else begin
                                    sp_in = sp_ff - 1'b1;
                                    if (top != q_item.code) begin
                                       err_in = ST_MISMATCH;
                                    end
                                 end
                              end
                              default: ;
                           endcase
                        end
                     end
                  end
               end
            end
            FUNC_EOL, FUNC_EOT: begin
               if (quote_ff) begin
                  err_in = ST_QUOTE;
               end else if (q_item.kind == FUNC_EOT && (block_ff || sp_ff != '0)) begin
                  err_in = ST_UNCLOSED;
               end
               quote_in    = 1'b0;
               line_in     = 1'b0;
               prev_in     = CLS_OTHER;
               consumed_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Keep the read port on the entry that will be the top after this word.
   assign ram_rd_addr = IDX_W'(sp_in - 1'b1);
   assign fwd_hit_in  = ram_wr_en && (ram_wr_addr == ram_rd_addr);

   cbn_ram #(
      .WIDTH (2),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         block_ff     <= 1'b0;
         line_ff      <= 1'b0;
         quote_ff     <= 1'b0;
         prev_ff      <= CLS_OTHER;
         consumed_ff  <= 1'b1;
         err_ff       <= ST_OK;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         block_ff     <= block_in;
         line_ff      <= line_in;
         quote_ff     <= quote_in;
         prev_ff      <= prev_in;
         consumed_ff  <= consumed_in;
         err_ff       <= err_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= ram_wr_data;
      if (fire) begin
         rsp_data_ff <= {5'b0, block_in, DEPTH_W'(sp_in), err_in};
         rsp_last_ff <= (q_item.kind == FUNC_EOT);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CBN_ASSERT_NEXT(a_err_sticky, clock, reset, err_ff != ST_OK, err_ff != ST_OK, "error cleared")
   `CBN_ASSERT_NEXT(a_err_frozen, clock, reset, err_ff != ST_OK,
                    $stable(sp_ff) && $stable(block_ff), "state moved after error")
   `CBN_ASSERT_HOLDS(a_sp_range, clock, reset, 1'b1, sp_ff <= SP_W'(STACK_DEPTH),
                     "stack pointer beyond depth")
   `CBN_ASSERT_NEXT(a_push_fwd, clock, reset, ram_wr_en, fwd_hit_ff, "push not forwarded to top")

endmodule

`default_nettype wire

// File: sv/c_bracket_nesting_checker.sv
// Top level of the C bracket nesting checker.
`default_nettype none

// Takes one word per cycle, sustained while rsp_tready is high: each word is a source
// character, an end-of-line or an end-of-text mark (kind in req_tuser) and gives exactly
// one result word. The classifying front end is combinational and writes each accepted
// word into a two-entry queue; the back end pops it and registers its result in the output
// register. The rate holds because the back end handles a word with no stall: the
// top-of-stack compare reads the stack RAM, whose read port always points at the next top,
// with a forwarding register covering a push in the cycle before. The stack RAM needs no
// clearing after reset, so words are accepted from the first cycle out of reset. Errors
// stay until reset; rsp_tlast marks the result of the end-of-text word.
module c_bracket_nesting_checker import cbn_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [2:0] status, [9:3] nesting_depth, [10] in_comment
   output logic             rsp_tlast    // final_res
);

   logic     q_full;
   logic     q_push;
   item_type q_push_item;
   logic     q_pop;
   logic     q_head_valid;
   item_type q_head_item;

   cbn_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   cbn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   cbn_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_head_valid),
      .q_item     (q_head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
